// ----- rtl/gbs_pkg.sv -----
// Shared constants, types and helper functions of the brush-stamp gray grid.
package gbs_pkg;

  localparam int GRID_SIDE  = 28;
  localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int CELL_W     = $clog2(GRID_SIDE);

  localparam int POS_W   = 16;
  localparam int OFS_W   = 12;
  localparam int CP_W    = 8;
  localparam int GRAY_W  = 8;
  localparam int COL_W   = 32;
  localparam int WGT_W   = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam int DIV_STEPS = OFS_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [COL_W-1:0]  OPAQUE_ALPHA = 32'hFF00_0000;
  localparam logic [GRAY_W-1:0] GRAY_MAX     = 8'd255;

  localparam logic [1:0] MODE_STAMP = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic [1:0] OUT_DONE    = 2'd0;
  localparam logic [1:0] OUT_OUTSIDE = 2'd1;
  localparam logic [1:0] OUT_ZERO    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_LEFT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CELLP = 3'd3;

  typedef struct packed {
    logic load;
    logic div_start;
    logic stamp_rd;
    logic stamp_wr;
    logic read_rd;
    logic sweep;
    logic out_load;
  } gbs_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       zero_size;
    logic       outside;
    logic       div_done;
    logic       brush_last;
    logic       sweep_last;
    logic       out_free;
  } gbs_stat_t;

  // Brush weight for offsets bx, by in 0..2 (centre at 1, 1).
  function automatic logic [WGT_W-1:0] brush_weight(input logic [1:0] bx,
                                                    input logic [1:0] by);
    logic cx;
    logic cy;
    cx = (bx == 2'd1);
    cy = (by == 2'd1);
    if (cx && cy) begin
      brush_weight = 7'd64;
    end else if (cx || cy) begin
      brush_weight = 7'd32;
    end else begin
      brush_weight = 7'd18;
    end
  endfunction

endpackage

// ----- rtl/gbs_in_if.sv -----
// Request channel carrying a mode and a position.
interface gbs_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        mode;
  logic signed [gbs_pkg::POS_W-1:0]  pos_x;
  logic signed [gbs_pkg::POS_W-1:0]  pos_y;

  modport source (output valid, output mode, output pos_x, output pos_y, input ready);
  modport sink   (input valid, input mode, input pos_x, input pos_y, output ready);
endinterface

// ----- rtl/gbs_out_if.sv -----
// Result channel carrying gray level, colour and outcome.
interface gbs_out_if;
  logic                         valid;
  logic                         ready;
  logic [gbs_pkg::GRAY_W-1:0]   gray_level;
  logic [gbs_pkg::COL_W-1:0]    pixel_colour;
  logic [1:0]                   outcome;

  modport source (output valid, output gray_level, output pixel_colour, output outcome,
                  input ready);
  modport sink   (input valid, input gray_level, input pixel_colour, input outcome,
                  output ready);
endinterface

// ----- rtl/gbs_div.sv -----
// Two-lane restoring divider, one quotient bit per lane per cycle.
module gbs_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [gbs_pkg::OFS_W-1:0]    dvd_x,
  input  logic [gbs_pkg::OFS_W-1:0]    dvd_y,
  input  logic [gbs_pkg::CP_W-1:0]     divisor,
  output logic [gbs_pkg::OFS_W-1:0]    quot_x,
  output logic [gbs_pkg::OFS_W-1:0]    quot_y,
  output logic                         done
);

  logic [gbs_pkg::OFS_W-1:0]     dvd_r   [2];
  logic [gbs_pkg::OFS_W-1:0]     dvd_nxt [2];
  logic [gbs_pkg::CP_W-1:0]      rem_r   [2];
  logic [gbs_pkg::CP_W-1:0]      rem_nxt [2];
  logic [gbs_pkg::CP_W:0]        trial   [2];
  logic [gbs_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [gbs_pkg::DIV_CNT_W-1:0] cnt_nxt;
  logic                          busy_r;
  logic                          busy_nxt;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      trial[i] = {rem_r[i], dvd_r[i][gbs_pkg::OFS_W-1]};
      if (trial[i] >= {1'b0, divisor}) begin
        rem_nxt[i] = gbs_pkg::CP_W'(trial[i] - {1'b0, divisor});
        dvd_nxt[i] = {dvd_r[i][gbs_pkg::OFS_W-2:0], 1'b1};
      end else begin
        rem_nxt[i] = trial[i][gbs_pkg::CP_W-1:0];
        dvd_nxt[i] = {dvd_r[i][gbs_pkg::OFS_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == gbs_pkg::DIV_CNT_W'(gbs_pkg::DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r[0] <= dvd_x;
      dvd_r[1] <= dvd_y;
      rem_r[0] <= '0;
      rem_r[1] <= '0;
    end else if (busy_r) begin
      dvd_r[0] <= dvd_nxt[0];
      dvd_r[1] <= dvd_nxt[1];
      rem_r[0] <= rem_nxt[0];
      rem_r[1] <= rem_nxt[1];
    end
  end

  assign quot_x = dvd_r[0];
  assign quot_y = dvd_r[1];
  assign done   = !busy_r;

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r && cnt_r == '0)
    else $error("divider did not start");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r <= gbs_pkg::DIV_CNT_W'(gbs_pkg::DIV_STEPS - 1))
    else $error("divider step count overrun");

  a_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !start && cnt_r == gbs_pkg::DIV_CNT_W'(gbs_pkg::DIV_STEPS - 1)) |=> done)
    else $error("divider did not finish");

endmodule

// ----- rtl/gbs_dpath.sv -----
// Datapath: configuration registers, checks, divider, cell memory and result register.
module gbs_dpath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [gbs_pkg::CFG_IDX_W-1:0]        cfg_idx,
  input  logic [gbs_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic [1:0]                           in_mode,
  input  logic signed [gbs_pkg::POS_W-1:0]     in_pos_x,
  input  logic signed [gbs_pkg::POS_W-1:0]     in_pos_y,
  input  logic                                 out_ready,
  input  gbs_pkg::gbs_cmd_t                    cmd,
  output gbs_pkg::gbs_stat_t                   stat,
  output logic                                 out_valid,
  output logic [gbs_pkg::GRAY_W-1:0]           out_gray_level,
  output logic [gbs_pkg::COL_W-1:0]            out_pixel_colour,
  output logic [1:0]                           out_outcome
);

  localparam int SW = gbs_pkg::POS_W + 1;

  logic [gbs_pkg::OFS_W-1:0]  left_r;
  logic [gbs_pkg::OFS_W-1:0]  top_r;
  logic [gbs_pkg::OFS_W-1:0]  span_r;
  logic [gbs_pkg::CP_W-1:0]   cellp_r;

  logic [1:0]                        mode_r;
  logic signed [gbs_pkg::POS_W-1:0]  pos_x_r;
  logic signed [gbs_pkg::POS_W-1:0]  pos_y_r;

  logic signed [SW-1:0] px;
  logic signed [SW-1:0] py;
  logic signed [SW-1:0] ox;
  logic signed [SW-1:0] oy;
  logic signed [SW-1:0] span_s;
  logic                 zero_size;
  logic                 out_stamp;
  logic                 out_read;
  logic                 outside;
  logic [1:0]           outcome;
  logic                 is_read;

  logic [gbs_pkg::OFS_W-1:0] dvd_x;
  logic [gbs_pkg::OFS_W-1:0] dvd_y;
  logic [gbs_pkg::OFS_W-1:0] qx;
  logic [gbs_pkg::OFS_W-1:0] qy;
  logic                      div_done;

  logic [1:0] bx_r;
  logic [1:0] by_r;
  logic [1:0] bx_nxt;
  logic [1:0] by_nxt;
  logic signed [gbs_pkg::OFS_W+1:0] tx;
  logic signed [gbs_pkg::OFS_W+1:0] ty;
  logic                             in_grid;
  logic [gbs_pkg::CELL_W-1:0]       scx;
  logic [gbs_pkg::CELL_W-1:0]       scy;
  logic [gbs_pkg::CELL_W-1:0]       rcx;
  logic [gbs_pkg::CELL_W-1:0]       rcy;
  logic [gbs_pkg::ADDR_W-1:0]       stamp_addr;
  logic [gbs_pkg::ADDR_W-1:0]       read_addr;
  logic [gbs_pkg::ADDR_W-1:0]       sweep_addr_r;
  logic [gbs_pkg::ADDR_W-1:0]       sweep_addr_nxt;
  logic                             sweep_last;

  logic [gbs_pkg::GRAY_W-1:0] mem [gbs_pkg::CELL_COUNT];
  logic [gbs_pkg::GRAY_W-1:0] rd_data_r;
  logic                       mem_re;
  logic [gbs_pkg::ADDR_W-1:0] mem_ra;
  logic                       mem_we;
  logic [gbs_pkg::ADDR_W-1:0] mem_wa;
  logic [gbs_pkg::GRAY_W-1:0] mem_wd;
  logic [gbs_pkg::GRAY_W:0]   sum;

  logic                       out_valid_r;
  logic                       out_valid_nxt;
  logic [gbs_pkg::GRAY_W-1:0] out_gray_r;
  logic [gbs_pkg::COL_W-1:0]  out_colour_r;
  logic [1:0]                 out_outcome_r;
  logic                       out_free;
  logic [gbs_pkg::GRAY_W-1:0] gray;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r  <= '0;
      top_r   <= '0;
      span_r  <= '0;
      cellp_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        gbs_pkg::REG_LEFT:  left_r  <= cfg_data;
        gbs_pkg::REG_TOP:   top_r   <= cfg_data;
        gbs_pkg::REG_SPAN:  span_r  <= cfg_data;
        gbs_pkg::REG_CELLP: cellp_r <= cfg_data[gbs_pkg::CP_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold the request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= in_mode;
      pos_x_r <= in_pos_x;
      pos_y_r <= in_pos_y;
    end
  end

  always_comb begin
    px        = {pos_x_r[gbs_pkg::POS_W-1], pos_x_r};
    py        = {pos_y_r[gbs_pkg::POS_W-1], pos_y_r};
    span_s    = $signed({{(SW - gbs_pkg::OFS_W){1'b0}}, span_r});
    ox        = px - $signed({{(SW - gbs_pkg::OFS_W){1'b0}}, left_r});
    oy        = py - $signed({{(SW - gbs_pkg::OFS_W){1'b0}}, top_r});
    zero_size = (span_r == '0) || (cellp_r == '0);
    out_stamp = (ox < 0) || (ox >= span_s) || (oy < 0) || (oy >= span_s);
    out_read  = (px < 0) || (px >= span_s) || (py < 0) || (py >= span_s);
    is_read   = (mode_r == gbs_pkg::MODE_READ);
    outside   = is_read ? out_read : out_stamp;
    if (mode_r == gbs_pkg::MODE_STAMP || mode_r == gbs_pkg::MODE_READ) begin
      if (zero_size) begin
        outcome = gbs_pkg::OUT_ZERO;
      end else if (outside) begin
        outcome = gbs_pkg::OUT_OUTSIDE;
      end else begin
        outcome = gbs_pkg::OUT_DONE;
      end
    end else begin
      outcome = gbs_pkg::OUT_DONE;
    end
    dvd_x = is_read ? px[gbs_pkg::OFS_W-1:0] : ox[gbs_pkg::OFS_W-1:0];
    dvd_y = is_read ? py[gbs_pkg::OFS_W-1:0] : oy[gbs_pkg::OFS_W-1:0];
  end

  gbs_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .dvd_x   (dvd_x),
    .dvd_y   (dvd_y),
    .divisor (cellp_r),
    .quot_x  (qx),
    .quot_y  (qy),
    .done    (div_done)
  );

  // Brush walk over the 3 by 3 neighbourhood
  always_comb begin
    bx_nxt = bx_r;
    by_nxt = by_r;
    if (cmd.div_start) begin
      bx_nxt = '0;
      by_nxt = '0;
    end else if (cmd.stamp_wr) begin
      if (bx_r == 2'd2) begin
        bx_nxt = '0;
        by_nxt = by_r + 2'd1;
      end else begin
        bx_nxt = bx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bx_r <= '0;
      by_r <= '0;
    end else begin
      bx_r <= bx_nxt;
      by_r <= by_nxt;
    end
  end

  always_comb begin
    tx = $signed({2'b00, qx}) + $signed({{gbs_pkg::OFS_W{1'b0}}, bx_r}) -
         $signed((gbs_pkg::OFS_W + 2)'(1));
    ty = $signed({2'b00, qy}) + $signed({{gbs_pkg::OFS_W{1'b0}}, by_r}) -
         $signed((gbs_pkg::OFS_W + 2)'(1));
    in_grid = (tx >= 0) && (tx < gbs_pkg::GRID_SIDE) && (ty >= 0) &&
              (ty < gbs_pkg::GRID_SIDE);
    scx = tx[gbs_pkg::CELL_W-1:0];
    scy = ty[gbs_pkg::CELL_W-1:0];
    stamp_addr = gbs_pkg::ADDR_W'(scy) * gbs_pkg::ADDR_W'(gbs_pkg::GRID_SIDE) +
                 gbs_pkg::ADDR_W'(scx);
    rcx = (qx >= gbs_pkg::OFS_W'(gbs_pkg::GRID_SIDE)) ?
          gbs_pkg::CELL_W'(gbs_pkg::GRID_SIDE - 1) : qx[gbs_pkg::CELL_W-1:0];
    rcy = (qy >= gbs_pkg::OFS_W'(gbs_pkg::GRID_SIDE)) ?
          gbs_pkg::CELL_W'(gbs_pkg::GRID_SIDE - 1) : qy[gbs_pkg::CELL_W-1:0];
    read_addr = gbs_pkg::ADDR_W'(rcy) * gbs_pkg::ADDR_W'(gbs_pkg::GRID_SIDE) +
                gbs_pkg::ADDR_W'(rcx);
  end

  // Clearing sweep address
  always_comb begin
    sweep_last     = (sweep_addr_r == gbs_pkg::ADDR_W'(gbs_pkg::CELL_COUNT - 1));
    sweep_addr_nxt = sweep_addr_r;
    if (cmd.sweep) begin
      sweep_addr_nxt = sweep_last ? '0 : sweep_addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_addr_r <= '0;
    end else begin
      sweep_addr_r <= sweep_addr_nxt;
    end
  end

  // Cell memory
  always_comb begin
    sum    = {1'b0, rd_data_r} +
             {{(gbs_pkg::GRAY_W + 1 - gbs_pkg::WGT_W){1'b0}},
              gbs_pkg::brush_weight(bx_r, by_r)};
    mem_re = cmd.stamp_rd || cmd.read_rd;
    mem_ra = cmd.read_rd ? read_addr : stamp_addr;
    mem_we = cmd.sweep || (cmd.stamp_wr && in_grid);
    mem_wa = cmd.sweep ? sweep_addr_r : stamp_addr;
    if (cmd.sweep) begin
      mem_wd = '0;
    end else if (sum[gbs_pkg::GRAY_W]) begin
      mem_wd = gbs_pkg::GRAY_MAX;
    end else begin
      mem_wd = sum[gbs_pkg::GRAY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_ra];
    end
  end

  // Result register
  always_comb begin
    out_free      = !out_valid_r || out_ready;
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    gray = (is_read && outcome == gbs_pkg::OUT_DONE) ? rd_data_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_gray_r    <= gray;
      out_colour_r  <= (is_read && outcome == gbs_pkg::OUT_DONE) ?
                       (gbs_pkg::OPAQUE_ALPHA | {8'h00, gray, gray, gray}) : '0;
      out_outcome_r <= outcome;
    end
  end

  always_comb begin
    stat.mode       = mode_r;
    stat.zero_size  = zero_size;
    stat.outside    = outside;
    stat.div_done   = div_done;
    stat.brush_last = (bx_r == 2'd2) && (by_r == 2'd2);
    stat.sweep_last = sweep_last;
    stat.out_free   = out_free;
  end

  assign out_valid        = out_valid_r;
  assign out_gray_level   = out_gray_r;
  assign out_pixel_colour = out_colour_r;
  assign out_outcome      = out_outcome_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> out_free)
    else $error("result overwritten before taken");

  a_sweep_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.sweep && sweep_last) |=> sweep_addr_r == '0)
    else $error("sweep address did not wrap");

  a_one_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.sweep && (cmd.stamp_wr || mem_re)))
    else $error("sweep collides with memory access");

endmodule

// ----- rtl/gbs_ctrl.sv -----
// Controller state machine sequencing the checks, divide, brush walk, read and sweep.
module gbs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  gbs_pkg::gbs_stat_t stat,
  output gbs_pkg::gbs_cmd_t  cmd
);

  localparam logic [2:0] S_SWEEP = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_BRD   = 3'd4;
  localparam logic [2:0] S_BWR   = 3'd5;
  localparam logic [2:0] S_RRD   = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       sweep_item_r;
  logic       sweep_item_nxt;

  always_comb begin
    state_nxt      = state_r;
    sweep_item_nxt = sweep_item_r;
    cmd            = '0;
    in_ready       = 1'b0;
    unique case (state_r)
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) begin
          state_nxt      = sweep_item_r ? S_FIN : S_IDLE;
          sweep_item_nxt = 1'b0;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.mode == gbs_pkg::MODE_CLEAR) begin
          sweep_item_nxt = 1'b1;
          state_nxt      = S_SWEEP;
        end else if ((stat.mode == gbs_pkg::MODE_STAMP || stat.mode == gbs_pkg::MODE_READ)
                     && !stat.zero_size && !stat.outside) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_nxt = (stat.mode == gbs_pkg::MODE_READ) ? S_RRD : S_BRD;
        end
      end
      S_BRD: begin
        cmd.stamp_rd = 1'b1;
        state_nxt    = S_BWR;
      end
      S_BWR: begin
        cmd.stamp_wr = 1'b1;
        state_nxt    = stat.brush_last ? S_FIN : S_BRD;
      end
      S_RRD: begin
        cmd.read_rd = 1'b1;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_SWEEP;
      sweep_item_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sweep_item_r <= sweep_item_nxt;
    end
  end

  a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWEEP && stat.sweep_last && sweep_item_r) |=> state_r == S_FIN)
    else $error("clear request lost its result");

  a_div_then_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BRD || state_r == S_RRD) |-> stat.div_done)
    else $error("memory access before divide finished");

  a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == S_CHECK)
    else $error("request taken outside idle");

endmodule

// ----- rtl/grid_brush_stamp_and_upscale_top.sv -----
// Top level of the brush-stamp gray grid with nearest-neighbour read-out.
// A rejected request or an unused mode goes from check to result; a read divides, then
// reads one cell; a stamp divides, then reads the nine brush cells and writes those in
// the grid; a clear writes every cell, one write per cell on the single write port.
// One request in flight: the next is taken once the result is loaded, later if held.
// After reset a sweep zeroes the cell memory before any request is taken.
module grid_brush_stamp_and_upscale_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [gbs_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [gbs_pkg::CFG_DATA_W-1:0]     cfg_data,
  gbs_in_if.sink                             in_ch,
  gbs_out_if.source                          out_ch
);

  gbs_pkg::gbs_cmd_t  cmd;
  gbs_pkg::gbs_stat_t stat;
  logic               in_ready;

  gbs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gbs_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_idx          (cfg_idx),
    .cfg_data         (cfg_data),
    .in_mode          (in_ch.mode),
    .in_pos_x         (in_ch.pos_x),
    .in_pos_y         (in_ch.pos_y),
    .out_ready        (out_ch.ready),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_ch.valid),
    .out_gray_level   (out_ch.gray_level),
    .out_pixel_colour (out_ch.pixel_colour),
    .out_outcome      (out_ch.outcome)
  );

  assign in_ch.ready = in_ready;

endmodule

// ----- tb/grid_result_checker.sv -----
// Checker for the brush-stamp gray grid: predicts every result and compares it.
`timescale 1ns / 100ps

module grid_result_checker
  import gbs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  gbs_in_if                     in_ch,
  gbs_out_if                    out_ch,
  output int                    mismatch_count,
  output int                    results_owed
);

  typedef struct packed {
    logic [GRAY_W-1:0] gray;
    logic [COL_W-1:0]  colour;
    logic [1:0]        outcome;
  } pixel_result_t;

  logic [GRAY_W-1:0] gray_cells [CELL_COUNT];
  logic [OFS_W-1:0]  left_q;
  logic [OFS_W-1:0]  top_q;
  logic [OFS_W-1:0]  span_q;
  logic [CP_W-1:0]   cellp_q;
  pixel_result_t     owed_q [$];

  function automatic int stroke_weight(int dx, int dy);
    int ring;
    ring = (dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy);
    if (ring == 0) begin
      return 64;
    end else if (ring == 1) begin
      return 32;
    end
    return 18;
  endfunction

  // Only the inner 3x3 is touched; its corners, at ring distance two, add 18.
  function automatic void stamp_cells(int col, int row);
    int c;
    int r;
    int sum;
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        c = col + dx;
        r = row + dy;
        if (c >= 0 && c < GRID_SIDE && r >= 0 && r < GRID_SIDE) begin
          sum = int'(gray_cells[r * GRID_SIDE + c]) + stroke_weight(dx, dy);
          gray_cells[r * GRID_SIDE + c] = (sum > int'(GRAY_MAX)) ? GRAY_MAX : sum[GRAY_W-1:0];
        end
      end
    end
  endfunction

  function automatic pixel_result_t grid_response(logic [1:0] mode,
                                                  logic signed [POS_W-1:0] x,
                                                  logic signed [POS_W-1:0] y);
    pixel_result_t res;
    int span;
    int cp;
    int ox;
    int oy;
    int col;
    int row;
    logic [GRAY_W-1:0] g;
    res = '0;
    span = int'(span_q);
    cp = int'(cellp_q);
    case (mode) inside
      MODE_CLEAR: begin
        foreach (gray_cells[i]) gray_cells[i] = '0;
      end
      MODE_STAMP, MODE_READ: begin
        if (span == 0 || cp == 0) begin
          res.outcome = OUT_ZERO;
        end else if (mode == MODE_STAMP) begin
          ox = int'(x) - int'(left_q);
          oy = int'(y) - int'(top_q);
          if (ox < 0 || ox >= span || oy < 0 || oy >= span) begin
            res.outcome = OUT_OUTSIDE;
          end else begin
            stamp_cells(ox / cp, oy / cp);
            res.outcome = OUT_DONE;
          end
        end else begin
          ox = int'(x);
          oy = int'(y);
          if (ox < 0 || ox >= span || oy < 0 || oy >= span) begin
            res.outcome = OUT_OUTSIDE;
          end else begin
            col = ox / cp;
            row = oy / cp;
            if (col >= GRID_SIDE) col = GRID_SIDE - 1;
            if (row >= GRID_SIDE) row = GRID_SIDE - 1;
            g = gray_cells[row * GRID_SIDE + col];
            res.gray = g;
            res.colour = OPAQUE_ALPHA | {8'h00, g, g, g};
            res.outcome = OUT_DONE;
          end
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    pixel_result_t want;
    pixel_result_t got;
    if (!rst_n) begin
      foreach (gray_cells[i]) gray_cells[i] = '0;
      left_q = '0;
      top_q = '0;
      span_q = '0;
      cellp_q = '0;
      owed_q.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_LEFT:  left_q = cfg_data;
          REG_TOP:   top_q = cfg_data;
          REG_SPAN:  span_q = cfg_data;
          REG_CELLP: cellp_q = cfg_data[CP_W-1:0];
          default: begin
          end
        endcase
      end
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got = '{out_ch.gray_level, out_ch.pixel_colour, out_ch.outcome};
        if (owed_q.size() == 0) begin
          if (mismatch_count < 10) begin
            $display("%0t: unexpected result gray %h colour %h outcome %0d", $realtime,
                     got.gray, got.colour, got.outcome);
          end
          mismatch_count++;
        end else begin
          want = owed_q.pop_front();
          if (got.gray !== want.gray || got.colour !== want.colour ||
              got.outcome !== want.outcome) begin
            if (mismatch_count < 10) begin
              $display({"%0t: result mismatch: expected gray %h colour %h outcome %0d, ",
                        "got gray %h colour %h outcome %0d"},
                       $realtime, want.gray, want.colour, want.outcome,
                       got.gray, got.colour, got.outcome);
            end
            mismatch_count++;
          end
        end
      end
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        owed_q.push_back(grid_response(in_ch.mode, in_ch.pos_x, in_ch.pos_y));
      end
    end
    results_owed = owed_q.size();
  end

endmodule

// ----- tb/grid_brush_stamp_and_upscale_top_test.sv -----
// Testbench top: stimulus, idling and verdict for the brush-stamp gray grid.
`timescale 1ns / 100ps

module grid_brush_stamp_and_upscale_top_test;
  import gbs_pkg::*;

  localparam int IDLE_PCT     = 29;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 150;
  localparam int DRAIN_CYCLES = 800;
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  quiet;
  int                    fail_count;
  int                    results_owed;
  int                    cycle_count = 0;
  int                    cur_left;
  int                    cur_top;
  int                    cur_span;

  gbs_in_if  in_ch ();
  gbs_out_if out_ch ();

  grid_brush_stamp_and_upscale_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  grid_result_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_data       (cfg_data),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .mismatch_count (fail_count),
    .results_owed   (results_owed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready = quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic wait_idle();
    while (results_owed != 0) @(negedge clk);
  endtask

  task automatic set_canvas(input int left, input int top, input int span, input int cellp);
    wait_idle();
    write_reg(REG_LEFT, CFG_DATA_W'(left));
    write_reg(REG_TOP, CFG_DATA_W'(top));
    write_reg(REG_SPAN, CFG_DATA_W'(span));
    write_reg(REG_CELLP, CFG_DATA_W'(cellp));
    cur_left = left;
    cur_top = top;
    cur_span = span;
  endtask

  task automatic send_request(input logic [1:0] mode, input logic signed [POS_W-1:0] x,
                              input logic signed [POS_W-1:0] y);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.mode = mode;
    in_ch.pos_x = x;
    in_ch.pos_y = y;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  function automatic logic signed [POS_W-1:0] pick_coord(input int base, input int span);
    int r;
    r = $urandom_range(99);
    if (span == 0 || r < 8) begin
      return POS_W'($urandom());
    end else if (r < 16) begin
      case ($urandom_range(3))
        0: return POS_W'(base - 1);
        1: return POS_W'(base);
        2: return POS_W'(base + span - 1);
        default: return POS_W'(base + span);
      endcase
    end
    return POS_W'(base + $urandom_range(span - 1));
  endfunction

  task automatic random_request();
    int r;
    r = $urandom_range(99);
    if (r < 55) begin
      send_request(MODE_STAMP, pick_coord(cur_left, cur_span), pick_coord(cur_top, cur_span));
    end else if (r < 93) begin
      send_request(MODE_READ, pick_coord(0, cur_span), pick_coord(0, cur_span));
    end else if (r < 95) begin
      send_request(MODE_CLEAR, POS_W'($urandom()), POS_W'($urandom()));
    end else begin
      send_request(MODE_UNUSED, POS_W'($urandom()), POS_W'($urandom()));
    end
  endtask

  initial begin
    int cellp;
    int span;
    int left;
    int top;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    quiet = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_STAMP;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    cur_left = 0;
    cur_top = 0;
    cur_span = 0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // registers still at reset: zero size everywhere
    send_request(MODE_STAMP, 16'sd0, 16'sd0);
    send_request(MODE_READ, 16'sd0, 16'sd0);
    send_request(MODE_UNUSED, 16'h8000, 16'h7FFF);
    send_request(MODE_CLEAR, 16'hFFFF, 16'h0000);
    set_canvas(0, 0, 100, 0);
    send_request(MODE_READ, 16'sd5, 16'sd5);
    set_canvas(0, 0, 0, 5);
    send_request(MODE_STAMP, 16'sd1, 16'sd1);

    set_canvas(100, 50, 560, 20);
    write_reg(REG_CELLP, 12'hF14);
    for (int i = int'(REG_CELLP) + 1; i < (1 << CFG_IDX_W); i++) begin
      write_reg(CFG_IDX_W'(i), 12'hFFF);
    end
    send_request(MODE_STAMP, 16'sd100, 16'sd50);
    send_request(MODE_STAMP, 16'sd659, 16'sd609);
    send_request(MODE_STAMP, 16'sd99, 16'sd50);
    send_request(MODE_STAMP, 16'sd100, 16'sd610);
    send_request(MODE_STAMP, -16'sd32768, 16'sd32767);
    repeat (4) send_request(MODE_STAMP, 16'sd380, 16'sd330);
    send_request(MODE_READ, 16'sd280, 16'sd280);
    send_request(MODE_READ, 16'sd300, 16'sd280);
    send_request(MODE_READ, 16'sd559, 16'sd559);
    send_request(MODE_READ, -16'sd1, 16'sd0);
    send_request(MODE_READ, 16'sd0, 16'sd560);
    send_request(MODE_CLEAR, 16'sd0, 16'sd0);
    send_request(MODE_READ, 16'sd280, 16'sd280);

    set_canvas(4095, 4095, 4095, 1);
    send_request(MODE_STAMP, 16'sd8189, 16'sd8189);
    send_request(MODE_STAMP, 16'sd4095, 16'sd4095);
    send_request(MODE_READ, 16'sd4094, 16'sd4094);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: set_canvas(4095, 4095, 4095, 255);
        1: set_canvas(10, 20, 6, 1);
        2: set_canvas(0, 0, 28, 1);
        7: set_canvas(0, 4095, 4095, 1);
        default: begin
          cellp = $urandom_range(1, 48);
          span = cellp * 28 + $urandom_range(2 * cellp) - cellp;
          if (span > 4095) span = 4095;
          if (span < 1) span = 1;
          left = ($urandom_range(4) == 0) ? (($urandom_range(1) == 0) ? 0 : 4095)
                                          : $urandom_range(4095);
          top = ($urandom_range(4) == 0) ? (($urandom_range(1) == 0) ? 0 : 4095)
                                         : $urandom_range(4095);
          set_canvas(left, top, span, cellp);
        end
      endcase
      quiet = (p == 3);
      repeat (PHASE_ITEMS) random_request();
    end
    quiet = 1'b0;

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && results_owed == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
